// ----- hw/rtl/ptp_pkg.sv -----
// Shared constants, command type and helpers for the point-in-polygon test core.
package ptp_pkg;

    localparam int COORD_BITS  = 16;                 // signed Q12.4 coordinate width
    localparam int DIFF_W      = COORD_BITS + 1;     // width of a coordinate difference
    localparam int TD_W        = 11;                 // touch_distance register width
    localparam int R_W         = TD_W + 4;           // touch radius in Q12.4 units
    localparam int MUL_W       = (DIFF_W > R_W + 2) ? DIFF_W : R_W + 2;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam logic [TD_W-1:0] TOUCH_RESET = TD_W'(20);

    // Command queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_FIRST  = 3'd0;  // open polygon, no result
    localparam logic [OP_W-1:0] OP_MID    = 3'd1;  // one edge, no result
    localparam logic [OP_W-1:0] OP_LAST   = 3'd2;  // edge plus closing edge, result
    localparam logic [OP_W-1:0] OP_SINGLE = 3'd3;  // one-vertex touch test, result
    localparam logic [OP_W-1:0] OP_EMPTY  = 3'd4;  // empty polygon, result 0

    typedef struct packed {
        logic [OP_W-1:0]              op;
        logic signed [COORD_BITS-1:0] qx;
        logic signed [COORD_BITS-1:0] qy;
        logic signed [COORD_BITS-1:0] vx;
        logic signed [COORD_BITS-1:0] vy;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
    } ptp_cmd_t;

    // Sign-extend a coordinate to multiplier operand width
    function automatic logic signed [MUL_W-1:0] ext_coord(
        input logic signed [COORD_BITS-1:0] v
    );
        ext_coord = {{(MUL_W - COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    // Sign-extend a product to sum width
    function automatic logic signed [SUM_W-1:0] ext_prod(
        input logic signed [PROD_W-1:0] p
    );
        ext_prod = {p[PROD_W-1], p};
    endfunction

endpackage

// ----- hw/rtl/point_in_polygon_test_core.sv -----
// Point-in-polygon test core (crossing number), top level.
//
// Polygons stream in one vertex per request, first and last vertex marked; the
// query point is taken from the first request. Each edge, plus the closing edge
// back to the first vertex, toggles a parity bit when it spans the query y and
// crosses strictly right of the query x, using an exact cross-multiplication.
// One result follows each last vertex, each one-vertex polygon (inside when
// within touch_distance whole pixels, inclusive) and each empty-shape request
// (always outside). Throughput is one vertex per clock while the output is not
// held back by out_ready: each request becomes a single command, and the edge
// pipeline evaluates both edges of a last vertex in parallel with four
// multipliers. An accepted command passes from the queue into the difference
// register, then into the product register, and the compare then loads the
// output register that drives out_valid. Input ready depends only on queue
// occupancy, and the result register lets a new request in while a result
// waits. touch_distance is written through cfg_we/cfg_wdata and must only
// change while the core is idle.
module point_in_polygon_test_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ptp_pkg::TD_W-1:0]             cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [ptp_pkg::COORD_BITS-1:0] query_x,
    input  logic signed [ptp_pkg::COORD_BITS-1:0] query_y,
    input  logic signed [ptp_pkg::COORD_BITS-1:0] vertex_x,
    input  logic signed [ptp_pkg::COORD_BITS-1:0] vertex_y,
    input  logic                                 first_vertex,
    input  logic                                 last_vertex,
    input  logic                                 empty_shape,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 inside_res
);

    logic [ptp_pkg::TD_W-1:0] touch_distance_reg;
    logic                     push_valid, push_ready, pop_valid, pop_ready;
    ptp_pkg::ptp_cmd_t        push_cmd, pop_cmd;

    // Touch radius register, whole pixels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            touch_distance_reg <= ptp_pkg::TOUCH_RESET;
        else if (cfg_we)
            touch_distance_reg <= cfg_wdata;
    end

    // Front end owns the held query, first and previous vertex
    ptp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .query_x      (query_x),
        .query_y      (query_y),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .first_vertex (first_vertex),
        .last_vertex  (last_vertex),
        .empty_shape  (empty_shape),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    // Decouples front-end accepts from back-end stalls
    ptp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Edge tests, parity and the result register
    ptp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .touch_distance (touch_distance_reg),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_cmd        (pop_cmd),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .inside_res     (inside_res)
    );

endmodule

// ----- hw/rtl/ptp_front.sv -----
// Front end: takes vertex requests, tracks polygon state, issues edge commands.
module ptp_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [ptp_pkg::COORD_BITS-1:0] query_x,
    input  logic signed [ptp_pkg::COORD_BITS-1:0] query_y,
    input  logic signed [ptp_pkg::COORD_BITS-1:0] vertex_x,
    input  logic signed [ptp_pkg::COORD_BITS-1:0] vertex_y,
    input  logic                                 first_vertex,
    input  logic                                 last_vertex,
    input  logic                                 empty_shape,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output ptp_pkg::ptp_cmd_t                    push_cmd
);

    logic signed [ptp_pkg::COORD_BITS-1:0] held_qx_reg, held_qy_reg;
    logic signed [ptp_pkg::COORD_BITS-1:0] start_x_reg, start_y_reg;
    logic signed [ptp_pkg::COORD_BITS-1:0] prior_x_reg, prior_y_reg;
    logic                                  take;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign take       = in_valid && push_ready;

    always_comb
    begin
        push_cmd.qx = first_vertex ? query_x : held_qx_reg;
        push_cmd.qy = first_vertex ? query_y : held_qy_reg;
        push_cmd.vx = vertex_x;
        push_cmd.vy = vertex_y;
        push_cmd.px = prior_x_reg;
        push_cmd.py = prior_y_reg;
        push_cmd.sx = start_x_reg;
        push_cmd.sy = start_y_reg;
        if (empty_shape)
            push_cmd.op = ptp_pkg::OP_EMPTY;
        else if (first_vertex && last_vertex)
            push_cmd.op = ptp_pkg::OP_SINGLE;
        else if (first_vertex)
            push_cmd.op = ptp_pkg::OP_FIRST;
        else if (last_vertex)
            push_cmd.op = ptp_pkg::OP_LAST;
        else
            push_cmd.op = ptp_pkg::OP_MID;
    end

    // Empty requests leave the held polygon state alone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_qx_reg <= '0;
            held_qy_reg <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            prior_x_reg <= '0;
            prior_y_reg <= '0;
        end
        else if (take && !empty_shape)
        begin
            if (first_vertex)
            begin
                held_qx_reg <= query_x;
                held_qy_reg <= query_y;
                start_x_reg <= vertex_x;
                start_y_reg <= vertex_y;
            end
            prior_x_reg <= vertex_x;
            prior_y_reg <= vertex_y;
        end
    end

endmodule

// ----- hw/rtl/ptp_queue.sv -----
// Short command queue between the front end and the edge pipeline.
module ptp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  ptp_pkg::ptp_cmd_t push_cmd,
    output logic              pop_valid,
    input  logic              pop_ready,
    output ptp_pkg::ptp_cmd_t pop_cmd
);

    ptp_pkg::ptp_cmd_t               entry_reg [ptp_pkg::QUEUE_DEPTH];
    logic [ptp_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [ptp_pkg::QCNT_W-1:0]      count_reg;
    logic                            do_push, do_pop;

    assign push_ready = (count_reg != ptp_pkg::QCNT_W'(ptp_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + ptp_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + ptp_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + ptp_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - ptp_pkg::QCNT_W'(1);
        end
    end

endmodule

// ----- hw/rtl/ptp_back.sv -----
// Edge pipeline: differences, cross products, compare and parity, result register.
module ptp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ptp_pkg::TD_W-1:0]      touch_distance,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  ptp_pkg::ptp_cmd_t             pop_cmd,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          inside_res
);

    localparam int MW = ptp_pkg::MUL_W;
    localparam int PW = ptp_pkg::PROD_W;
    localparam int SW = ptp_pkg::SUM_W;

    // Stage A: differences
    logic                  a_valid_reg;
    logic [ptp_pkg::OP_W-1:0] a_op_reg;
    logic                  a_span0_reg, a_span1_reg;
    logic signed [MW-1:0]  a_den0_reg, a_qa0_reg, a_pb0_reg, a_qc0_reg;
    logic signed [MW-1:0]  a_den1_reg, a_qa1_reg, a_pb1_reg, a_qc1_reg;

    // Stage B: products
    logic                  b_valid_reg;
    logic [ptp_pkg::OP_W-1:0] b_op_reg;
    logic                  b_span0_reg, b_span1_reg, b_pos0_reg, b_pos1_reg;
    logic signed [PW-1:0]  b_m0_reg, b_m1_reg, b_m2_reg, b_m3_reg;

    logic                  parity_reg, parity_next;
    logic                  out_valid_reg, inside_reg;

    logic signed [MW-1:0]  qx, qy, vx, vy, px, py, sx, sy;
    logic signed [MW-1:0]  opa0, opb0, opa1, opb1, opa2, opb2, radius;
    logic                  single_b;
    logic                  c_need_out, c_go, b_free, a_free;
    logic                  hit0, hit1, inside_c, result_c;
    logic signed [SW-1:0]  dist2, touch2;

    assign qx = ptp_pkg::ext_coord(pop_cmd.qx);
    assign qy = ptp_pkg::ext_coord(pop_cmd.qy);
    assign vx = ptp_pkg::ext_coord(pop_cmd.vx);
    assign vy = ptp_pkg::ext_coord(pop_cmd.vy);
    assign px = ptp_pkg::ext_coord(pop_cmd.px);
    assign py = ptp_pkg::ext_coord(pop_cmd.py);
    assign sx = ptp_pkg::ext_coord(pop_cmd.sx);
    assign sy = ptp_pkg::ext_coord(pop_cmd.sy);

    // Stage C decides; a result only waits on the output register
    assign c_need_out = (b_op_reg == ptp_pkg::OP_LAST) || (b_op_reg == ptp_pkg::OP_SINGLE) ||
                        (b_op_reg == ptp_pkg::OP_EMPTY);
    assign c_go       = b_valid_reg && (!c_need_out || !out_valid_reg || out_ready);
    assign b_free     = !b_valid_reg || c_go;
    assign a_free     = !a_valid_reg || b_free;
    assign pop_ready  = a_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_valid_reg <= pop_valid;
            if (b_free)
                b_valid_reg <= a_valid_reg;
        end
    end

    // Edge 0: prior -> vertex. Edge 1: vertex -> start (closing edge).
    always_ff @(posedge clk)
    begin
        if (a_free && pop_valid)
        begin
            a_op_reg    <= pop_cmd.op;
            a_span0_reg <= (vy > qy) != (py > qy);
            a_span1_reg <= (sy > qy) != (vy > qy);
            a_den0_reg  <= py - vy;
            a_qa0_reg   <= qx - vx;
            a_pb0_reg   <= px - vx;
            a_qc0_reg   <= qy - vy;
            a_den1_reg  <= vy - sy;
            a_qa1_reg   <= qx - sx;
            a_pb1_reg   <= vx - sx;
            a_qc1_reg   <= qy - sy;
        end
    end

    // Single vertex reuses the multipliers: (q-v)^2 terms and radius^2
    assign single_b = (a_op_reg == ptp_pkg::OP_SINGLE);
    assign radius   = {{(MW - ptp_pkg::R_W){1'b0}}, touch_distance, 4'b0000};
    assign opa0     = a_qa0_reg;
    assign opb0     = single_b ? a_qa0_reg : a_den0_reg;
    assign opa1     = single_b ? a_qc0_reg : a_pb0_reg;
    assign opb1     = a_qc0_reg;
    assign opa2     = single_b ? radius : a_qa1_reg;
    assign opb2     = single_b ? radius : a_den1_reg;

    always_ff @(posedge clk)
    begin
        if (b_free && a_valid_reg)
        begin
            b_op_reg    <= a_op_reg;
            b_span0_reg <= a_span0_reg;
            b_span1_reg <= a_span1_reg;
            b_pos0_reg  <= !a_den0_reg[MW-1] && (a_den0_reg != '0);
            b_pos1_reg  <= !a_den1_reg[MW-1] && (a_den1_reg != '0);
            b_m0_reg    <= opa0 * opb0;
            b_m1_reg    <= opa1 * opb1;
            b_m2_reg    <= opa2 * opb2;
            b_m3_reg    <= a_pb1_reg * a_qc1_reg;
        end
    end

    // Stage C: crossing right of query when lhs < rhs (sense flips with den sign)
    assign hit0     = b_span0_reg && (b_pos0_reg ? (b_m0_reg < b_m1_reg) : (b_m1_reg < b_m0_reg));
    assign hit1     = b_span1_reg && (b_pos1_reg ? (b_m2_reg < b_m3_reg) : (b_m3_reg < b_m2_reg));
    assign dist2    = ptp_pkg::ext_prod(b_m0_reg) + ptp_pkg::ext_prod(b_m1_reg);
    assign touch2   = ptp_pkg::ext_prod(b_m2_reg);
    assign inside_c = !(touch2 < dist2);

    always_comb
    begin
        parity_next = parity_reg;
        result_c    = 1'b0;
        unique case (b_op_reg)
            ptp_pkg::OP_FIRST:
            begin
                parity_next = 1'b0;
            end
            ptp_pkg::OP_MID:
            begin
                parity_next = parity_reg ^ hit0;
            end
            ptp_pkg::OP_LAST:
            begin
                parity_next = parity_reg ^ hit0 ^ hit1;
                result_c    = parity_next;
            end
            ptp_pkg::OP_SINGLE:
            begin
                parity_next = 1'b0;
                result_c    = inside_c;
            end
            ptp_pkg::OP_EMPTY:
            begin
                parity_next = 1'b0;
            end
            default:
            begin
                parity_next = parity_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_go)
                parity_reg <= parity_next;
            if (c_go && c_need_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_go && c_need_out)
            inside_reg <= result_c;
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

endmodule
